[rtl/core/mwo_pkg.sv]
// mwo_pkg: shared constants, register and waveform codes for the oscillator
// also holds the sine table generator evaluated at elaboration
// no dependencies
`default_nettype none

package mwo_pkg;

  // default sizing
  localparam int PHASE_BITS_DEF = 32;
  localparam int SINE_DEPTH_DEF = 256;

  // field widths
  localparam int STEP_W      = 32;
  localparam int GAIN_W      = 16;
  localparam int WAVE_W      = 3;
  localparam int FRAC_W      = 14;
  localparam int SAMPLE_W    = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WAVEFORM   = 2'd2;

  // register reset values
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd32768;

  // waveform codes
  localparam logic [WAVE_W-1:0] WAVE_SAW       = 3'd0;
  localparam logic [WAVE_W-1:0] WAVE_SHIFT_SAW = 3'd1;
  localparam logic [WAVE_W-1:0] WAVE_STEP_TRI  = 3'd2;
  localparam logic [WAVE_W-1:0] WAVE_SAW_BLEND = 3'd3;
  localparam logic [WAVE_W-1:0] WAVE_TRI       = 3'd4;
  localparam logic [WAVE_W-1:0] WAVE_TRI_BLEND = 3'd5;
  localparam logic [WAVE_W-1:0] WAVE_SINE_PAIR = 3'd6;
  localparam logic [WAVE_W-1:0] WAVE_MIX       = 3'd7;

  // pi/2 in Q30
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  // sine of a Q30 angle in Q14, Taylor series to the 13th power
  function automatic logic [14:0] sine_q14(input longint unsigned a);
    longint unsigned mag;
    longint          sum;
    longint unsigned v;
    mag = a;
    sum = longint'(a);
    for (int n = 1; n <= 6; n++) begin
      mag = (mag * a) >> 30;
      mag = (mag * a) >> 30;
      case (n)
        1:       mag = mag / 64'd6;
        2:       mag = mag / 64'd20;
        3:       mag = mag / 64'd42;
        4:       mag = mag / 64'd72;
        5:       mag = mag / 64'd110;
        default: mag = mag / 64'd156;
      endcase
      if ((n % 2) == 1) begin
        sum = sum - longint'(mag);
      end else begin
        sum = sum + longint'(mag);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = ((unsigned'(sum) * 64'd16384) + (64'd1 << 29)) >> 30;
    if (v > 64'd16384) begin
      v = 64'd16384;
    end
    return 15'(v);
  endfunction

endpackage

`default_nettype wire

[rtl/core/multi_waveform_oscillator_top.sv]
// Throughput: one tick per cycle unless the sample channel stalls;
// four register stages (fraction, shape terms, waveform, scaled sample),
// one multiplier in each of the last two.
// ready falls only when all four stages hold results and out_ready is low.
// Reset: phase cleared, phase_step 0, gain unity, waveform saw, pipeline empty.
// multi_waveform_oscillator_top: phase accumulator, shaper and gain stage
// depends on mwo_pkg
`default_nettype none

module multi_waveform_oscillator_top #(
  parameter int PHASE_BITS       = mwo_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = mwo_pkg::SINE_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration writes
  input  wire logic                                cfg_we,
  input  wire logic [mwo_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [mwo_pkg::CFG_DATA_W-1:0]      cfg_data,
  // tick channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                restart,
  // sample channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [mwo_pkg::SAMPLE_W-1:0]      sample
);

  localparam int FW     = mwo_pkg::FRAC_W;
  localparam int D      = SINE_TABLE_DEPTH;
  localparam int IW     = $clog2(D + 1);
  localparam int PW     = $clog2(4 * D);
  localparam int CW     = $clog2(9 * D);
  localparam int PROD_W = FW + $clog2(4 * D + 1);
  localparam int SUM_W  = (PHASE_BITS > mwo_pkg::STEP_W) ? PHASE_BITS : mwo_pkg::STEP_W;

  // shape term kinds
  localparam logic [1:0] KIND_DIRECT = 2'd0;
  localparam logic [1:0] KIND_BLEND  = 2'd1;
  localparam logic [1:0] KIND_SINE   = 2'd2;

  // Q14 constants
  localparam logic signed [17:0] ONE  = 18'sd16384;
  localparam logic signed [17:0] HALF = 18'sd8192;
  localparam logic signed [17:0] QTR  = 18'sd4096;

  // blend division: floor(n/6) via offset, halving and reciprocal of 3
  localparam logic signed [19:0] BLEND_OFS = 20'sd120003;
  localparam logic [18:0]        RECIP3    = 19'd349526;
  localparam logic signed [17:0] BLEND_BIAS = 18'sd20000;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [17:0] val;
    logic [IW-1:0]      idx_s;
    logic               neg_s;
    logic [IW-1:0]      idx_c;
    logic               neg_c;
  } shape_terms_t;

  // configuration registers
  logic [mwo_pkg::STEP_W-1:0] phase_step;
  logic [mwo_pkg::GAIN_W-1:0] gain;
  logic [mwo_pkg::WAVE_W-1:0] waveform;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= '0;
      gain       <= mwo_pkg::GAIN_RESET;
      waveform   <= mwo_pkg::WAVE_SAW;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mwo_pkg::REG_PHASE_STEP: phase_step <= cfg_data[mwo_pkg::STEP_W-1:0];
        mwo_pkg::REG_GAIN:       gain       <= cfg_data[mwo_pkg::GAIN_W-1:0];
        mwo_pkg::REG_WAVEFORM:   waveform   <= cfg_data[mwo_pkg::WAVE_W-1:0];
        default: ;
      endcase
    end
  end

  // quarter-wave sine table, constant
  logic [14:0] quarter_tab [D+1];

  for (genvar k = 0; k <= D; k++) begin : g_tab
    localparam longint unsigned A_K = (mwo_pkg::PI_HALF_Q30 * k) / SINE_TABLE_DEPTH;
    assign quarter_tab[k] = mwo_pkg::sine_q14(A_K);
  end

  // pipeline flow control
  logic v1, v2, v3;
  logic en1, en2, en3, en4;
  logic accept;

  assign en4      = !out_valid || out_ready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;
  assign accept   = in_valid && en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) out_valid <= v3;
    end
  end

  // phase accumulator: sample the fraction, then advance
  logic [PHASE_BITS-1:0] phase;
  logic [PHASE_BITS-1:0] phase_base;
  logic [PHASE_BITS-1:0] phase_next;
  logic [SUM_W-1:0]      step_w;
  logic [PHASE_BITS-1:0] step_ext;
  logic [FW-1:0]         x1;

  assign step_w     = SUM_W'(phase_step);
  assign step_ext   = step_w[PHASE_BITS-1:0];
  assign phase_base = restart ? '0 : phase;
  assign phase_next = phase_base + step_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      x1 <= phase_base[PHASE_BITS-1 -: FW];
    end
  end

  // basic shapes on a Q0.14 fraction
  function automatic logic signed [17:0] saw_f(input logic [FW-1:0] x);
    logic signed [17:0] xs;
    xs = $signed({4'd0, x});
    return (xs < HALF) ? (ONE - xs) : (xs - 18'sd24576);
  endfunction

  function automatic logic signed [17:0] shift_saw_f(input logic [FW-1:0] x);
    logic signed [17:0] xs;
    xs = $signed({4'd0, x});
    return (xs < HALF) ? (xs + HALF) : -xs;
  endfunction

  function automatic logic signed [17:0] tri_f(input logic [FW-1:0] x);
    logic signed [17:0] ys;
    ys = $signed({2'd0, x, 2'b00});
    if (ys < ONE) begin
      return ys;
    end else if (ys < 18'sd49152) begin
      return 18'sd32768 - ys;
    end
    return ys - 18'sd65536;
  endfunction

  function automatic logic signed [17:0] step_tri_f(input logic [FW-1:0] x);
    logic [14:0]        y;
    logic               neg;
    logic [2:0]         cnt;
    logic signed [17:0] lvl;
    y   = {x, 1'b0};
    neg = (y > 15'd16384);
    if (neg) y = y - 15'd16384;
    if (y > 15'd8192) y = 15'd16384 - y;
    cnt = 3'(y > 15'd6553) + 3'(y > 15'd4915) + 3'(y > 15'd3276) + 3'(y > 15'd1638);
    lvl = $signed({3'd0, cnt, 12'd0});
    return neg ? -lvl : lvl;
  endfunction

  // table position to {negate, quarter index}
  function automatic logic [IW:0] quad_map(input logic [PW-1:0] pos);
    logic [PW:0] p;
    logic [PW:0] r;
    logic        neg;
    p = (PW+1)'(pos);
    if (p < (PW+1)'(D)) begin
      r = p;
      neg = 1'b0;
    end else if (p < (PW+1)'(2 * D)) begin
      r = (PW+1)'(2 * D) - p;
      neg = 1'b0;
    end else if (p < (PW+1)'(3 * D)) begin
      r = p - (PW+1)'(2 * D);
      neg = 1'b1;
    end else begin
      r = (PW+1)'(4 * D) - p;
      neg = 1'b1;
    end
    return {neg, IW'(r)};
  endfunction

  // stage 2: shape terms
  logic signed [17:0] saw_x, ssaw_x, stri_x, tri_x, saw_2x, tri_2x;
  logic signed [19:0] blend_saw_n, blend_tri_n;
  logic [PROD_W-1:0]  p_prod;
  logic [PW-1:0]      p_pos;
  logic [CW-1:0]      c_raw;
  logic [PW-1:0]      c_pos;
  logic [IW:0]        map_s, map_c;
  logic [FW-1:0]      x_off;
  shape_terms_t       pre_next;
  shape_terms_t       pre;
  shape_terms_t       direct_t, sine_t;

  always_comb begin
    saw_x  = saw_f(x1);
    ssaw_x = shift_saw_f(x1);
    stri_x = step_tri_f(x1);
    tri_x  = tri_f(x1);
    saw_2x = saw_f({x1[FW-2:0], 1'b0});
    x_off  = {x1[FW-2:0], 1'b0} + FW'(3277);
    tri_2x = tri_f(x_off);

    blend_saw_n = 20'(4 * 20'(saw_x)) + 20'(2 * 20'(saw_2x)) + BLEND_OFS;
    blend_tri_n = 20'(4 * 20'(tri_x)) + 20'(2 * 20'(tri_2x)) + BLEND_OFS;

    // sine positions: p and 2p + D, wrapped to one period
    p_prod = PROD_W'(x1) * PROD_W'(4 * D);
    p_pos  = PW'(p_prod >> FW);
    c_raw  = CW'(p_pos) + CW'(p_pos) + CW'(D);
    if (c_raw >= CW'(8 * D)) begin
      c_pos = PW'(c_raw - CW'(8 * D));
    end else if (c_raw >= CW'(4 * D)) begin
      c_pos = PW'(c_raw - CW'(4 * D));
    end else begin
      c_pos = PW'(c_raw);
    end
    map_s = quad_map(p_pos);
    map_c = quad_map(c_pos);

    sine_t.kind  = KIND_SINE;
    sine_t.val   = '0;
    sine_t.idx_s = map_s[IW-1:0];
    sine_t.neg_s = map_s[IW];
    sine_t.idx_c = map_c[IW-1:0];
    sine_t.neg_c = map_c[IW];

    direct_t      = sine_t;
    direct_t.kind = KIND_DIRECT;

    // select by waveform
    pre_next = direct_t;
    case (waveform)
      mwo_pkg::WAVE_SAW:       pre_next.val = saw_x;
      mwo_pkg::WAVE_SHIFT_SAW: pre_next.val = ssaw_x;
      mwo_pkg::WAVE_STEP_TRI:  pre_next.val = stri_x;
      mwo_pkg::WAVE_TRI:       pre_next.val = tri_x;
      mwo_pkg::WAVE_SAW_BLEND: begin
        pre_next.kind = KIND_BLEND;
        pre_next.val  = $signed({1'b0, blend_saw_n[17:1]});
      end
      mwo_pkg::WAVE_TRI_BLEND: begin
        pre_next.kind = KIND_BLEND;
        pre_next.val  = $signed({1'b0, blend_tri_n[17:1]});
      end
      mwo_pkg::WAVE_SINE_PAIR: pre_next = sine_t;
      default: begin
        if ($signed({4'd0, x1}) < QTR) begin
          pre_next.val = ssaw_x;
        end else if ($signed({4'd0, x1}) < HALF) begin
          pre_next.val = 18'sd12288;
        end else if ($signed({4'd0, x1}) < 18'sd12288) begin
          pre_next.val = tri_x;
        end else begin
          pre_next = sine_t;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      pre <= pre_next;
    end
  end

  // stage 3: blend division or sine lookup
  logic [35:0]        blend_prod;
  logic signed [17:0] blend_w;
  logic signed [17:0] tab_s, tab_c;
  logic signed [18:0] sine_sum;
  logic signed [17:0] w_next;
  logic signed [17:0] w3;

  always_comb begin
    blend_prod = 36'(pre.val[16:0]) * 36'(RECIP3);
    blend_w    = $signed({2'd0, blend_prod[35:20]}) - BLEND_BIAS;
    tab_s      = $signed({3'd0, quarter_tab[pre.idx_s]});
    tab_c      = $signed({3'd0, quarter_tab[pre.idx_c]});
    if (pre.neg_s) tab_s = -tab_s;
    if (pre.neg_c) tab_c = -tab_c;
    sine_sum   = 19'(tab_s) + 19'(tab_c) + 19'sd1;
    case (pre.kind)
      KIND_BLEND: w_next = blend_w;
      KIND_SINE:  w_next = 18'(sine_sum >>> 1);
      default:    w_next = pre.val;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      w3 <= w_next;
    end
  end

  // stage 4: gain, round and saturate
  logic signed [34:0] gain_prod;
  logic signed [34:0] scaled;

  always_comb begin
    gain_prod = 35'(w3) * $signed({19'd0, gain});
    scaled    = (gain_prod + 35'sd16384) >>> 15;
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      if (scaled > 35'sd32767) begin
        sample <= 16'sh7fff;
      end else if (scaled < -35'sd32768) begin
        sample <= 16'sh8000;
      end else begin
        sample <= scaled[15:0];
      end
    end
  end

`ifndef NO_ASSERTIONS
  // a restart tick leaves the phase at exactly one step
  a_restart_phase: assert property (@(posedge clk) disable iff (rst)
    (accept && restart) |=> (phase == $past(step_ext)))
    else $error("phase after restart is not one step");

  // phase moves only on a tick transfer
  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(phase))
    else $error("phase changed without a tick");

  // the fraction register takes the sampled phase
  a_frac_sample: assert property (@(posedge clk) disable iff (rst)
    accept |=> (x1 == $past(phase_base[PHASE_BITS-1 -: FW])))
    else $error("fraction does not match phase");

  // back pressure only with every stage occupied
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (v1 && v2 && v3 && out_valid))
    else $error("tick stalled with a free stage");

  // sine table indexes stay inside the quarter table
  a_tab_index: assert property (@(posedge clk) disable iff (rst)
    (v2 && pre.kind == KIND_SINE) |-> (pre.idx_s <= IW'(D) && pre.idx_c <= IW'(D)))
    else $error("quarter table index out of range");
`endif

endmodule

`default_nettype wire

[verif/tb.sv]
// tb: self-checking bench for multi_waveform_oscillator_top
// predicts every sample from its own phase, shape and gain model and checks it in order
// depends on mwo_pkg and multi_waveform_oscillator_top
`timescale 1ns / 1ps

module tb;

  localparam int SINE_DEPTH = 256;
  localparam int Q14_ONE = 16384;
  localparam int Q14_HALF = 8192;
  localparam int Q14_QTR = 4096;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  // index with no register behind it
  localparam logic [mwo_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
  localparam int MAX_REPORTS = 50;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [mwo_pkg::CFG_INDEX_W-1:0] cfg_index = mwo_pkg::REG_PHASE_STEP;
  logic [mwo_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic restart = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [mwo_pkg::SAMPLE_W-1:0] sample;

  // oscillator state mirrored by the predictor
  logic [mwo_pkg::STEP_W-1:0] osc_phase = '0;
  logic [mwo_pkg::STEP_W-1:0] osc_step = '0;
  logic [mwo_pkg::GAIN_W-1:0] osc_gain = mwo_pkg::GAIN_RESET;
  logic [mwo_pkg::WAVE_W-1:0] osc_wave = mwo_pkg::WAVE_SAW;
  int sine_quarter [0:SINE_DEPTH];

  logic signed [mwo_pkg::SAMPLE_W-1:0] expected_samples [$];
  logic signed [mwo_pkg::SAMPLE_W-1:0] next_expected;

  int src_idle_pct = 13;
  int sink_idle_pct = 51;
  int sink_hold = 0;
  int errors = 0;
  int ticks_sent = 0;
  int samples_checked = 0;

  multi_waveform_oscillator_top u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .restart(restart),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sample(sample)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // quarter-wave sine in Q14 from a truncating Q30 Taylor series
  initial begin : sine_quarter_init
    longint unsigned ang;
    longint unsigned mag;
    longint unsigned rnd;
    longint acc;
    int k;
    int n;
    for (k = 0; k <= SINE_DEPTH; k++) begin
      ang = (HALF_PI_Q30 * longint'(k)) / SINE_DEPTH;
      mag = ang;
      acc = longint'(ang);
      for (n = 1; n <= 6; n++) begin
        mag = (mag * ang) >> 30;
        mag = (mag * ang) >> 30;
        mag = mag / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - longint'(mag);
        end else begin
          acc = acc + longint'(mag);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      rnd = (longint'(acc) * 16384 + (64'd1 << 29)) >> 30;
      sine_quarter[k] = (rnd > Q14_ONE) ? Q14_ONE : int'(rnd);
    end
  end

  function automatic longint floor_div(input longint num, input longint den);
    if (num >= 0) begin
      return num / den;
    end
    return -((-num + den - 1) / den);
  endfunction

  function automatic int saw_w(input int x);
    return (x < Q14_HALF) ? Q14_ONE - x : x - 3 * Q14_HALF;
  endfunction

  function automatic int shifted_saw_w(input int x);
    return (x < Q14_HALF) ? x + Q14_HALF : -x;
  endfunction

  function automatic int tri_w(input int x);
    int y;
    y = 4 * x;
    if (y < Q14_ONE) begin
      return y;
    end
    if (y < 3 * Q14_ONE) begin
      return 2 * Q14_ONE - y;
    end
    return y - 4 * Q14_ONE;
  endfunction

  // rounded (2a + b) / 3
  function automatic int blend_w(input int a, input int b);
    return int'(floor_div(2 * (2 * longint'(a) + b) + 3, 6));
  endfunction

  function automatic int sine_at(input longint pos);
    longint quad;
    longint ofs;
    pos = pos % (4 * SINE_DEPTH);
    quad = pos / SINE_DEPTH;
    ofs = pos % SINE_DEPTH;
    case (quad)
      0: return sine_quarter[ofs];
      1: return sine_quarter[SINE_DEPTH - ofs];
      2: return -sine_quarter[ofs];
      default: return -sine_quarter[SINE_DEPTH - ofs];
    endcase
  endfunction

  function automatic int sine_pair_w(input int x);
    longint pos;
    pos = (longint'(x) * 4 * SINE_DEPTH) >> 14;
    return int'(floor_div(sine_at(pos) + sine_at(2 * pos + SINE_DEPTH) + 1, 2));
  endfunction

  function automatic int shape_w(input logic [mwo_pkg::WAVE_W-1:0] mode, input int x);
    int y;
    int sgn;
    int lvl;
    case (mode)
      mwo_pkg::WAVE_SAW: return saw_w(x);
      mwo_pkg::WAVE_SHIFT_SAW: return shifted_saw_w(x);
      mwo_pkg::WAVE_STEP_TRI: begin
        y = 2 * x;
        sgn = 1;
        lvl = 0;
        if (y > Q14_ONE) begin
          sgn = -1;
          y = y - Q14_ONE;
        end
        if (y > Q14_HALF) begin
          y = Q14_ONE - y;
        end
        if (y > 6553) lvl += 4096;
        if (y > 4915) lvl += 4096;
        if (y > 3276) lvl += 4096;
        if (y > 1638) lvl += 4096;
        return sgn * lvl;
      end
      mwo_pkg::WAVE_SAW_BLEND:
        return blend_w(saw_w(x), saw_w((2 * x) & (Q14_ONE - 1)));
      mwo_pkg::WAVE_TRI: return tri_w(x);
      mwo_pkg::WAVE_TRI_BLEND:
        return blend_w(tri_w(x), tri_w((2 * x + 3277) & (Q14_ONE - 1)));
      mwo_pkg::WAVE_SINE_PAIR: return sine_pair_w(x);
      default: begin
        if (x < Q14_QTR) return shifted_saw_w(x);
        if (x < Q14_HALF) return 12288;
        if (x < 3 * Q14_QTR) return tri_w(x);
        return sine_pair_w(x);
      end
    endcase
  endfunction

  // one tick: form the sample from the current phase, then advance it
  function automatic logic signed [mwo_pkg::SAMPLE_W-1:0] predict_sample(input logic rs);
    int x;
    int w;
    longint s;
    if (rs) begin
      osc_phase = '0;
    end
    x = int'(osc_phase[mwo_pkg::STEP_W-1 -: mwo_pkg::FRAC_W]);
    w = shape_w(osc_wave, x);
    s = floor_div(longint'(w) * longint'(osc_gain) + 16384, 32768);
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    osc_phase = osc_phase + osc_step;
    return mwo_pkg::SAMPLE_W'(s);
  endfunction

  // output check first, then queue the prediction for a tick transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: sample %0d with nothing expected", $time, sample);
        end else begin
          next_expected = expected_samples.pop_front();
          samples_checked++;
          if (sample !== next_expected) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: sample mismatch expected %0d actual %0d",
                       $time, next_expected, sample);
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_samples.push_back(predict_sample(restart));
        ticks_sent++;
      end
    end
  end

  // sample sink: random stalls, or a long hold when one is requested
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      out_ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // all tasks start and end just after a falling edge
  task automatic send_tick(input logic rs);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    restart <= rs;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [mwo_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [mwo_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mwo_pkg::REG_PHASE_STEP: osc_step = data;
      mwo_pkg::REG_GAIN: osc_gain = data[mwo_pkg::GAIN_W-1:0];
      mwo_pkg::REG_WAVEFORM: osc_wave = data[mwo_pkg::WAVE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // defaults after reset: zero step, saw, unity gain
  task automatic test_reset_defaults();
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    wait_drain();
  endtask

  // each shape at x = 0 and at one boundary or threshold of interest
  task automatic test_each_waveform();
    logic [mwo_pkg::WAVE_W-1:0] shapes [8] = '{mwo_pkg::WAVE_SAW, mwo_pkg::WAVE_SHIFT_SAW,
                                               mwo_pkg::WAVE_STEP_TRI, mwo_pkg::WAVE_SAW_BLEND,
                                               mwo_pkg::WAVE_TRI, mwo_pkg::WAVE_TRI_BLEND,
                                               mwo_pkg::WAVE_SINE_PAIR, mwo_pkg::WAVE_MIX};
    int focus [8] = '{8192, 8191, 820, 16383, 12288, 6554, 4096, 4095};
    for (int i = 0; i < 8; i++) begin
      write_reg(mwo_pkg::REG_WAVEFORM, mwo_pkg::CFG_DATA_W'(shapes[i]));
      write_reg(mwo_pkg::REG_PHASE_STEP, mwo_pkg::CFG_DATA_W'(focus[i]) << 18);
      send_tick(1'b1);
      send_tick(1'b0);
      wait_drain();
    end
  endtask

  // saturation, zero gain, phase wrap, spare index and oversized writes
  task automatic test_register_extremes();
    write_reg(mwo_pkg::REG_WAVEFORM, mwo_pkg::CFG_DATA_W'(mwo_pkg::WAVE_SAW));
    write_reg(mwo_pkg::REG_GAIN, 32'h0000_FFFF);
    write_reg(mwo_pkg::REG_PHASE_STEP, 32'hFFFF_FFFF);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    wait_drain();
    write_reg(mwo_pkg::REG_GAIN, 32'h0000_0000);
    send_tick(1'b0);
    wait_drain();
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    write_reg(mwo_pkg::REG_GAIN, 32'hABCD_8000);
    write_reg(mwo_pkg::REG_WAVEFORM, 32'hFFFF_FFF9);
    send_tick(1'b1);
    send_tick(1'b0);
    wait_drain();
  endtask

  task automatic randomize_voice();
    logic [mwo_pkg::CFG_DATA_W-1:0] step;
    logic [mwo_pkg::CFG_DATA_W-1:0] vol;
    case ($urandom_range(5))
      0: step = '0;
      1: step = 32'hFFFF_FFFF;
      2: step = $urandom();
      3: step = ($urandom_range(16383) << 18) | $urandom_range(3);
      4: step = $urandom_range(65535) << 10;
      default: step = $urandom_range(8) << 18;
    endcase
    case ($urandom_range(4))
      0: vol = 32'd0;
      1: vol = 32'd65535;
      2: vol = 32'd32768;
      default: vol = $urandom();
    endcase
    if ($urandom_range(7) == 0) begin
      write_reg(REG_SPARE, $urandom());
    end
    write_reg(mwo_pkg::REG_PHASE_STEP, step);
    write_reg(mwo_pkg::REG_GAIN, vol);
    write_reg(mwo_pkg::REG_WAVEFORM, $urandom());
  endtask

  // random voices, notes restarted now and then
  task automatic test_random_ticks(input int src_pct, input int sink_pct, input int blocks);
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    repeat (blocks) begin
      randomize_voice();
      repeat (60) send_tick($urandom_range(9) == 0);
      wait_drain();
    end
  endtask

  // sink holds off long enough for the pipeline to fill and stall ticks
  task automatic test_output_stall();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    randomize_voice();
    @(posedge clk);
    sink_hold = 80;
    @(negedge clk);
    repeat (40) send_tick($urandom_range(9) == 0);
    wait_drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_defaults();
    test_each_waveform();
    test_register_extremes();
    test_random_ticks(13, 51, 6);
    test_random_ticks(51, 13, 6);
    test_random_ticks(0, 0, 6);
    test_output_stall();
    repeat (10) @(posedge clk);
    if (expected_samples.size() != 0) begin
      errors++;
      $display("%0t: %0d samples never arrived", $time, expected_samples.size());
    end
    $display("tb: %0d ticks, %0d samples checked: all eight shapes, gain and step extremes,",
             ticks_sent, samples_checked);
    $display("tb: phase wrap, restarts, three idle mixes and a long output stall");
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("tb: timeout with %0d samples outstanding", expected_samples.size());
    $display("tb: FAIL");
    $finish;
  end

endmodule
